### hw/rtl/dq_pkg.sv
// Shared constants, codes and types for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_TAIL  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK_TAIL = 3'd2;
  localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd3;
  localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd4;
  localparam logic [OP_W-1:0] OP_PEEK_HEAD = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } dq_state_t;

  typedef struct packed {
    logic exec;
    logic capture;
  } dq_cmd_t;

endpackage

### hw/rtl/dq_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

endmodule

### hw/rtl/dq_ctrl.sv
// Handshake controller: accepts one word, waits for the RAM read, presents the result.
`timescale 1ns / 1ps
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dq_cmd_t cmd
);

  dq_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd.exec      = 1'b0;
    cmd.capture   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (out_valid_r && out_ready) begin
          out_valid_nxt = 1'b0;
        end
        if (in_valid && in_ready) begin
          cmd.exec  = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.capture   = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/dq_datapath.sv
// Ring pointers, word store and result registers of the double-ended queue.
`timescale 1ns / 1ps
module dq_datapath
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dq_cmd_t             cmd,
  input  logic [OP_W-1:0]     in_op,
  input  logic [WORD_W-1:0]   in_data_in,
  output logic [WORD_W-1:0]   out_data_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  pend_rd_r;
  logic [STATUS_W-1:0]   pend_status_r;
  logic [COUNT_W-1:0]    pend_count_r;
  logic [WORD_W-1:0]     data_out_r;
  logic [STATUS_W-1:0]   status_r;
  logic [COUNT_W-1:0]    count_out_r;

  logic                  full, empty;
  logic [SUM_W-1:0]      sum;
  logic [IDX_W-1:0]      head_dec, head_inc;
  logic [IDX_W-1:0]      ram_addr;
  logic                  ram_we;
  logic                  rd_ok;
  logic [STATUS_W-1:0]   status_c;
  logic [DATA_WIDTH-1:0] ram_rdata;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] v);
    if (v >= SUM_W'(DEPTH)) begin
      return IDX_W'(v - SUM_W'(DEPTH));
    end
    return IDX_W'(v);
  endfunction

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign sum      = SUM_W'(head_r) + SUM_W'(count_r);
  assign head_dec = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    ram_addr  = head_r;
    ram_we    = 1'b0;
    rd_ok     = 1'b0;
    status_c  = ST_OK;
    case (in_op)
      OP_PUSH_TAIL: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          ram_addr  = wrap_idx(sum);
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_PUSH_HEAD: begin
        if (full) begin
          status_c = ST_FULL;
        end else begin
          head_nxt  = head_dec;
          ram_addr  = head_dec;
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      OP_POP_TAIL, OP_PEEK_TAIL: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          ram_addr = wrap_idx(sum - 1'b1);
          rd_ok    = 1'b1;
          if (in_op == OP_POP_TAIL) begin
            count_nxt = count_r - 1'b1;
          end
        end
      end
      OP_POP_HEAD, OP_PEEK_HEAD: begin
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          rd_ok = 1'b1;
          if (in_op == OP_POP_HEAD) begin
            head_nxt  = head_inc;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (cmd.exec && ram_we),
    .addr    (ram_addr),
    .wdata   (DATA_WIDTH'(in_data_in)),
    .rdata_r (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pend_rd_r     <= rd_ok;
      pend_status_r <= status_c;
      pend_count_r  <= COUNT_W'(count_nxt);
    end
    if (cmd.capture) begin
      data_out_r  <= pend_rd_r ? WORD_W'(ram_rdata) : '0;
      status_r    <= pend_status_r;
      count_out_r <= pend_count_r;
    end
  end

  assign out_data_out = data_out_r;
  assign out_status   = status_r;
  assign out_count    = count_out_r;

endmodule

### hw/rtl/double_ended_queue_core.sv
// Top level of the double-ended queue: controller plus datapath.
//
// Double-ended queue of DEPTH words held in a ring buffer (a single-port RAM
// addressed from a head index and a stored count). Each input word carries one
// operation: push, pop or peek at the tail or at the head; every operation
// returns exactly one result with the word read (zero otherwise), a status
// (ok, empty on pop/peek, full on push) and the count after the operation.
// An accepted operation passes the FETCH state, where the registered read port
// of the ring RAM delivers the word, into the result register. A new word is
// accepted only in IDLE while the result port keeps up; the result register
// lets it in as the previous result is taken. The RAM needs no clearing pass.
`timescale 1ns / 1ps
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [WORD_W-1:0]   in_data_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [WORD_W-1:0]   out_data_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count
);

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_op        (in_op),
    .in_data_in   (in_data_in),
    .out_data_out (out_data_out),
    .out_status   (out_status),
    .out_count    (out_count)
  );

endmodule

### tb/double_ended_queue_checker.sv
// Result checker for the double-ended queue: predicts each result and compares it.
`timescale 1ns / 1ps
module double_ended_queue_checker
  import dq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [WORD_W-1:0]   in_data_in,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [WORD_W-1:0]   out_data_out,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [COUNT_W-1:0]  out_count,
  output int                  fail_count,
  output int                  pending
);

  localparam int IDX_W = $clog2(DEPTH_DEF);

  typedef struct packed {
    logic [WORD_W-1:0]   data;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } deque_result_t;

  logic [WORD_W-1:0]  ring [DEPTH_DEF];
  logic [IDX_W-1:0]   head_idx;
  logic [COUNT_W-1:0] used;
  deque_result_t      results_due [$];
  int                 mismatches;

  initial begin
    fail_count = 0;
    pending    = 0;
    mismatches = 0;
  end

  function automatic deque_result_t apply_deque_op(logic [OP_W-1:0] op,
                                                   logic [WORD_W-1:0] word);
    deque_result_t    r;
    logic [IDX_W-1:0] slot;
    r = '0;
    case (op)
      OP_PUSH_TAIL, OP_PUSH_HEAD: begin
        if (used == COUNT_W'(DEPTH_DEF)) begin
          r.status = ST_FULL;
        end else begin
          if (op == OP_PUSH_TAIL) begin
            slot = head_idx + used[IDX_W-1:0];
          end else begin
            head_idx = head_idx - 1'b1;
            slot     = head_idx;
          end
          ring[slot] = word;
          used       = used + 1'b1;
        end
      end
      OP_POP_TAIL, OP_PEEK_TAIL, OP_POP_HEAD, OP_PEEK_HEAD: begin
        if (used == '0) begin
          r.status = ST_EMPTY;
        end else if (op inside {OP_POP_TAIL, OP_PEEK_TAIL}) begin
          slot   = head_idx + used[IDX_W-1:0] - 1'b1;
          r.data = ring[slot];
          if (op == OP_POP_TAIL) used = used - 1'b1;
        end else begin
          r.data = ring[head_idx];
          if (op == OP_POP_HEAD) begin
            head_idx = head_idx + 1'b1;
            used     = used - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.count = used;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    deque_result_t got;
    deque_result_t want;
    if (!rst_n) begin
      head_idx = '0;
      used     = '0;
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.data   = out_data_out;
        got.status = out_status;
        got.count  = out_count;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word data=%h status=%0d count=%0d",
                     $time, got.data, got.status, got.count);
        end else begin
          want = results_due.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.count !== want.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch expected %h/%0d/%0d got %h/%0d/%0d",
                       $time, want.data, want.status, want.count,
                       got.data, got.status, got.count);
          end
        end
      end
      if (in_valid && in_ready)
        results_due.push_back(apply_deque_op(in_op, in_data_in));
    end
    fail_count <= mismatches;
    pending    <= results_due.size();
  end

endmodule

### tb/double_ended_queue_core_tb.sv
// Testbench top for the double-ended queue: stimulus, reset and verdict.
`timescale 1ns / 1ps
module double_ended_queue_core_tb;
  import dq_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP_HI = 3'd7;
  localparam int RANDOM_BLOCKS = 32;
  localparam int BLOCK_ITEMS   = 32;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_PERIODIC, RDY_STRETCH} ready_mode_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = OP_PUSH_TAIL;
  logic [WORD_W-1:0]   in_data_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [WORD_W-1:0]   out_data_out;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;
  int                  fail_count;
  int                  pending;
  int                  burst_left = 0;
  ready_mode_t         ready_mode = RDY_ALWAYS;
  logic [7:0]          mode_cycles = '0;

  double_ended_queue_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_data_in  (in_data_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data_out(out_data_out),
    .out_status  (out_status),
    .out_count   (out_count)
  );

  double_ended_queue_checker results_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_data_in  (in_data_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data_out(out_data_out),
    .out_status  (out_status),
    .out_count   (out_count),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    mode_cycles <= mode_cycles + 1'b1;
    if (mode_cycles == '0) ready_mode <= ready_mode_t'($urandom_range(3));
    case (ready_mode)
      RDY_ALWAYS:   out_ready <= 1'b1;
      RDY_COIN:     out_ready <= 1'($urandom_range(1));
      RDY_PERIODIC: out_ready <= (mode_cycles[1:0] == 2'b00);
      default:      if ($urandom_range(7) == 0) out_ready <= ~out_ready;
    endcase
  end

  task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_op      <= op;
    in_data_in <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(op_mix_t mix);
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) return ($urandom_range(1) != 0) ? OP_NOP_HI : OP_NOP_LO;
    if (mix == MIX_EVEN) begin
      case ($urandom_range(5))
        0:       return OP_PUSH_TAIL;
        1:       return OP_POP_TAIL;
        2:       return OP_PEEK_TAIL;
        3:       return OP_PUSH_HEAD;
        4:       return OP_POP_HEAD;
        default: return OP_PEEK_HEAD;
      endcase
    end
    if ((mix == MIX_FILL) == (roll < 72))
      return ($urandom_range(1) != 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
    case ($urandom_range(3))
      0:       return OP_POP_TAIL;
      1:       return OP_POP_HEAD;
      2:       return OP_PEEK_TAIL;
      default: return OP_PEEK_HEAD;
    endcase
  endfunction

  initial begin
    op_mix_t mix;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_POP_TAIL, '1);
    send_word(OP_PEEK_TAIL, '1);
    send_word(OP_POP_HEAD, '1);
    send_word(OP_PEEK_HEAD, '1);
    send_word(OP_NOP_LO, '1);
    send_word(OP_NOP_HI, $urandom);
    send_word(OP_PUSH_TAIL, '0);
    send_word(OP_PUSH_HEAD, '1);
    for (int i = 2; i < DEPTH_DEF; i++)
      send_word((i % 2 != 0) ? OP_PUSH_HEAD : OP_PUSH_TAIL, $urandom);
    send_word(OP_PUSH_TAIL, $urandom);
    send_word(OP_PUSH_HEAD, $urandom);
    send_word(OP_PEEK_TAIL, '0);
    send_word(OP_PEEK_HEAD, '0);

    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      mix = op_mix_t'($urandom_range(2));
      for (int i = 0; i < BLOCK_ITEMS; i++)
        send_word(pick_op(mix), pick_word());
      if (b % 8 == 3) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
